// File: hw/rtl/fjos_pkg.sv
package fjos_pkg;

  localparam int MAX_TEXT_BYTES = 65536;
  localparam int POS_CAP_INT = (MAX_TEXT_BYTES - 1 < 65535) ? MAX_TEXT_BYTES - 1 : 65535;
  localparam logic [15:0] POS_CAP = 16'(POS_CAP_INT);

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  typedef enum logic [1:0] {
    KIND_MEMBER = 2'd0,
    KIND_OK     = 2'd1,
    KIND_FAIL   = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_OPEN  = 3'd1,
    ERR_NO_KEY   = 3'd2,
    ERR_NO_COLON = 3'd3,
    ERR_NO_VALUE = 3'd4,
    ERR_NO_NEXT  = 3'd5
  } err_code_t;

  typedef enum logic [2:0] {
    STEP_OPEN  = 3'd0,
    STEP_KEY   = 3'd1,
    STEP_COLON = 3'd2,
    STEP_VALUE = 3'd3,
    STEP_NEXT  = 3'd4
  } step_t;

  typedef enum logic [3:0] {
    TOK_NONE,
    TOK_END,
    TOK_BAD,
    TOK_LBRACE,
    TOK_RBRACE,
    TOK_LBRACKET,
    TOK_RBRACKET,
    TOK_COLON,
    TOK_COMMA,
    TOK_STR,
    TOK_INT
  } tok_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [15:0]  key_start;
    logic [15:0]  key_length;
    logic [15:0]  value_start;
    logic [15:0]  value_length;
    logic         value_is_integer;
    err_code_t    error_code;
    logic         last_result;
  } out_item_t;

  typedef struct packed {
    step_t       step;
    logic        finished;
    logic [15:0] key_start;
    logic [15:0] key_length;
  } grammar_t;

  typedef struct packed {
    grammar_t  g;
    logic      emit;
    out_item_t item;
  } parse_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  function automatic parse_t fail_with(parse_t r, err_code_t e);
    parse_t f;
    f = r;
    f.emit = 1'b1;
    f.item.result_kind = KIND_FAIL;
    f.item.error_code = e;
    f.g.finished = 1'b1;
    return f;
  endfunction

  // Applies one token to the grammar and reports the result beat it causes, if any.
  function automatic parse_t parse_token(grammar_t g, tok_t t, logic [15:0] start,
                                         logic [15:0] len);
    parse_t r;
    r.g = g;
    r.emit = 1'b0;
    r.item = '0;
    if (t != TOK_NONE && !g.finished) begin
      case (g.step)
        STEP_OPEN: begin
          if (t == TOK_LBRACE) r.g.step = STEP_KEY;
          else r = fail_with(r, ERR_NO_OPEN);
        end
        STEP_KEY: begin
          if (t == TOK_STR) begin
            r.g.key_start = start;
            r.g.key_length = len;
            r.g.step = STEP_COLON;
          end else begin
            r = fail_with(r, ERR_NO_KEY);
          end
        end
        STEP_COLON: begin
          if (t == TOK_COLON) r.g.step = STEP_VALUE;
          else r = fail_with(r, ERR_NO_COLON);
        end
        STEP_VALUE: begin
          if (t == TOK_STR || t == TOK_INT) begin
            r.emit = 1'b1;
            r.item.result_kind = KIND_MEMBER;
            r.item.key_start = g.key_start;
            r.item.key_length = g.key_length;
            r.item.value_start = start;
            r.item.value_length = len;
            r.item.value_is_integer = (t == TOK_INT);
            r.g.step = STEP_NEXT;
          end else begin
            r = fail_with(r, ERR_NO_VALUE);
          end
        end
        STEP_NEXT: begin
          if (t == TOK_COMMA) begin
            r.g.step = STEP_KEY;
          end else if (t == TOK_RBRACE) begin
            r.emit = 1'b1;
            r.item.result_kind = KIND_OK;
            r.g.finished = 1'b1;
          end else begin
            r = fail_with(r, ERR_NO_NEXT);
          end
        end
        default: begin
          r = fail_with(r, ERR_NO_NEXT);
        end
      endcase
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/flat_json_object_scanner.sv
// Scans a flat JSON object arriving one byte per beat, with last_byte on the final byte, and
// reports each member's key and value spans, then one ok or error result, ignoring further
// bytes until the text ends. Each byte is lexed and parsed in the cycle it is accepted, so a
// new byte can be taken every cycle; results go through a four-entry queue and leave at one
// per cycle while out_stall is low. A byte that closes an integer and also ends the object
// yields two results, and in_stall rises while the queue has room for fewer than two, so input
// pauses only after the result side has stalled long enough to leave three results queued.
module flat_json_object_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fjos_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fjos_pkg::out_item_t out_data
);

  logic            accept;
  logic            nearly_full;
  fjos_pkg::push_t push;

  assign in_stall = nearly_full;
  assign accept = in_valid && !in_stall;

  fjos_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push)
  );

  fjos_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .nearly_full (nearly_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: hw/rtl/fjos_scan.sv
module fjos_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  fjos_pkg::in_item_t item,
  output fjos_pkg::push_t   push
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_INT
  } mode_t;

  logic [15:0]       pos_r, pos_nxt;
  mode_t             mode_r, mode_nxt;
  logic [15:0]       tstart_r, tstart_nxt;
  fjos_pkg::grammar_t g_r, g_nxt;

  logic [7:0]        c;
  logic              is_dig;
  logic              scan;
  logic [16:0]       pos_wide;
  logic [15:0]       pos_inc;
  logic [15:0]       span_p;
  logic [15:0]       span_end;
  mode_t             mode_lex;
  logic [15:0]       tstart_lex;
  fjos_pkg::tok_t    tok1, tok2, tok3, tok4;
  fjos_pkg::parse_t  pr [4];
  fjos_pkg::out_item_t first, second;
  logic [1:0]        n;

  assign c = item.data_byte;
  assign is_dig = (c inside {[fjos_pkg::CH_ZERO:fjos_pkg::CH_NINE]});
  assign pos_wide = {1'b0, pos_r} + 17'd1;
  assign pos_inc = (pos_wide > {1'b0, fjos_pkg::POS_CAP}) ? fjos_pkg::POS_CAP : pos_wide[15:0];
  assign span_p = (pos_r >= tstart_r) ? pos_r - tstart_r : 16'd0;

  always_comb begin
    mode_lex = mode_r;
    tstart_lex = tstart_r;
    tok1 = fjos_pkg::TOK_NONE;
    tok2 = fjos_pkg::TOK_NONE;
    tok3 = fjos_pkg::TOK_NONE;
    tok4 = fjos_pkg::TOK_NONE;
    scan = 1'b0;
    if (!g_r.finished) begin
      if (mode_r == MODE_STR) begin
        if (c == fjos_pkg::CH_QUOTE) begin
          mode_lex = MODE_IDLE;
          tok1 = fjos_pkg::TOK_STR;
        end
      end else if (mode_r == MODE_INT) begin
        if (!is_dig) begin
          mode_lex = MODE_IDLE;
          tok1 = fjos_pkg::TOK_INT;
          scan = 1'b1;
        end
      end else begin
        scan = 1'b1;
      end
      if (scan) begin
        case (c)
          fjos_pkg::CH_LBRACE:   tok2 = fjos_pkg::TOK_LBRACE;
          fjos_pkg::CH_RBRACE:   tok2 = fjos_pkg::TOK_RBRACE;
          fjos_pkg::CH_LBRACKET: tok2 = fjos_pkg::TOK_LBRACKET;
          fjos_pkg::CH_RBRACKET: tok2 = fjos_pkg::TOK_RBRACKET;
          fjos_pkg::CH_COLON:    tok2 = fjos_pkg::TOK_COLON;
          fjos_pkg::CH_COMMA:    tok2 = fjos_pkg::TOK_COMMA;
          fjos_pkg::CH_QUOTE: begin
            mode_lex = MODE_STR;
            tstart_lex = pos_inc;
          end
          default: begin
            if (is_dig) begin
              mode_lex = MODE_INT;
              tstart_lex = pos_r;
            end
          end
        endcase
      end
      if (item.last_byte) begin
        if (mode_lex == MODE_INT) tok3 = fjos_pkg::TOK_INT;
        else if (mode_lex == MODE_STR) tok3 = fjos_pkg::TOK_BAD;
        tok4 = fjos_pkg::TOK_END;
      end
    end
  end

  assign span_end = (pos_inc >= tstart_lex) ? pos_inc - tstart_lex : 16'd0;

  assign pr[0] = fjos_pkg::parse_token(g_r, tok1, tstart_r, span_p);
  assign pr[1] = fjos_pkg::parse_token(pr[0].g, tok2, 16'd0, 16'd0);
  assign pr[2] = fjos_pkg::parse_token(pr[1].g, tok3, tstart_lex, span_end);
  assign pr[3] = fjos_pkg::parse_token(pr[2].g, tok4, 16'd0, 16'd0);

  // At most two of the four token steps can emit: a member and then a final result.
  always_comb begin
    n = 2'd0;
    first = '0;
    second = '0;
    for (int i = 0; i < 4; i++) begin
      if (pr[i].emit) begin
        if (n == 2'd0) begin
          first = pr[i].item;
          n = 2'd1;
        end else if (n == 2'd1) begin
          second = pr[i].item;
          n = 2'd2;
        end
      end
    end
    if (n == 2'd1) first.last_result = 1'b1;
    if (n == 2'd2) second.last_result = 1'b1;
  end

  assign push.count = accept ? n : 2'd0;
  assign push.first = first;
  assign push.second = second;

  always_comb begin
    if (item.last_byte) begin
      pos_nxt = 16'd0;
      mode_nxt = MODE_IDLE;
      tstart_nxt = 16'd0;
      g_nxt = '{step: fjos_pkg::STEP_OPEN, finished: 1'b0, key_start: 16'd0,
                key_length: 16'd0};
    end else begin
      pos_nxt = pos_inc;
      mode_nxt = mode_lex;
      tstart_nxt = tstart_lex;
      g_nxt = pr[3].g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 16'd0;
      mode_r <= MODE_IDLE;
      tstart_r <= 16'd0;
      g_r <= '{step: fjos_pkg::STEP_OPEN, finished: 1'b0, key_start: 16'd0,
               key_length: 16'd0};
    end else if (accept) begin
      pos_r <= pos_nxt;
      mode_r <= mode_nxt;
      tstart_r <= tstart_nxt;
      g_r <= g_nxt;
    end
  end

  a_no_beat_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> !g_r.finished)
    else $error("result produced after the text was finished");

  a_pair_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> push.first.result_kind == fjos_pkg::KIND_MEMBER &&
                           push.second.result_kind != fjos_pkg::KIND_MEMBER &&
                           push.second.last_result)
    else $error("second result of a byte is not the final one");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.last_byte |=> pos_r == 16'd0 && mode_r == MODE_IDLE &&
                                 g_r.step == fjos_pkg::STEP_OPEN && !g_r.finished)
    else $error("scanner did not restart after the last byte");

endmodule

// File: hw/rtl/fjos_fifo.sv
module fjos_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  fjos_pkg::push_t     push,
  output logic                nearly_full,
  output logic                out_valid,
  input  logic                out_stall,
  output fjos_pkg::out_item_t out_data
);

  fjos_pkg::out_item_t             mem [fjos_pkg::OUT_DEPTH];
  logic [fjos_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [fjos_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [fjos_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            pop;

  assign out_valid = (count_r != '0);
  assign out_data = mem[rd_ptr_r];
  assign pop = out_valid && !out_stall;
  assign nearly_full = (count_r > fjos_pkg::CNT_W'(fjos_pkg::OUT_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + fjos_pkg::PTR_W'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + fjos_pkg::PTR_W'(pop);
  assign count_nxt = count_r + fjos_pkg::CNT_W'(push.count) - fjos_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + fjos_pkg::PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_room_for_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> !nearly_full)
    else $error("results pushed while the queue lacks room for two");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fjos_pkg::CNT_W'(fjos_pkg::OUT_DEPTH))
    else $error("queue count beyond its depth");

endmodule

// File: dv/fjos_checker.sv
`timescale 1ns / 1ps
module fjos_checker
  import fjos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_STR,
    LEX_INT
  } lex_mode_t;

  lex_mode_t   lex;
  step_t       step;
  logic        done;
  logic [15:0] text_pos;
  logic [15:0] tok_begin;
  logic [15:0] key_begin;
  logic [15:0] key_len;
  out_item_t   byte_results[2];
  int          n_results;
  out_item_t   expected_q[$];

  function automatic logic [15:0] sat_next(logic [15:0] p);
    logic [16:0] n;
    n = {1'b0, p} + 17'd1;
    return (n > {1'b0, POS_CAP}) ? POS_CAP : n[15:0];
  endfunction

  function automatic logic [15:0] span_to(logic [15:0] stop);
    return (stop >= tok_begin) ? stop - tok_begin : 16'd0;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_text();
    lex = LEX_IDLE;
    step = STEP_OPEN;
    done = 1'b0;
    text_pos = '0;
    tok_begin = '0;
    key_begin = '0;
    key_len = '0;
  endtask

  task automatic give(out_item_t r);
    if (n_results < 2) begin
      byte_results[n_results] = r;
      n_results++;
    end
  endtask

  task automatic feed_grammar(tok_t t, logic [15:0] start, logic [15:0] len);
    out_item_t r;
    err_code_t e;
    r = '0;
    e = ERR_NONE;
    if (!done) begin
      case (step)
        STEP_OPEN: begin
          if (t == TOK_LBRACE) step = STEP_KEY;
          else e = ERR_NO_OPEN;
        end
        STEP_KEY: begin
          if (t == TOK_STR) begin
            key_begin = start;
            key_len = len;
            step = STEP_COLON;
          end else begin
            e = ERR_NO_KEY;
          end
        end
        STEP_COLON: begin
          if (t == TOK_COLON) step = STEP_VALUE;
          else e = ERR_NO_COLON;
        end
        STEP_VALUE: begin
          if (t == TOK_STR || t == TOK_INT) begin
            r.result_kind = KIND_MEMBER;
            r.key_start = key_begin;
            r.key_length = key_len;
            r.value_start = start;
            r.value_length = len;
            r.value_is_integer = (t == TOK_INT);
            give(r);
            step = STEP_NEXT;
          end else begin
            e = ERR_NO_VALUE;
          end
        end
        default: begin
          if (t == TOK_COMMA) begin
            step = STEP_KEY;
          end else if (t == TOK_RBRACE) begin
            r.result_kind = KIND_OK;
            give(r);
            done = 1'b1;
          end else begin
            e = ERR_NO_NEXT;
          end
        end
      endcase
      if (e != ERR_NONE) begin
        r = '0;
        r.result_kind = KIND_FAIL;
        r.error_code = e;
        give(r);
        done = 1'b1;
      end
    end
  endtask

  task automatic scan_idle(logic [7:0] c, logic [15:0] p);
    case (c)
      CH_LBRACE:   feed_grammar(TOK_LBRACE, '0, '0);
      CH_RBRACE:   feed_grammar(TOK_RBRACE, '0, '0);
      CH_LBRACKET: feed_grammar(TOK_LBRACKET, '0, '0);
      CH_RBRACKET: feed_grammar(TOK_RBRACKET, '0, '0);
      CH_COLON:    feed_grammar(TOK_COLON, '0, '0);
      CH_COMMA:    feed_grammar(TOK_COMMA, '0, '0);
      CH_QUOTE: begin
        lex = LEX_STR;
        tok_begin = sat_next(p);
      end
      default: begin
        if (is_digit(c)) begin
          lex = LEX_INT;
          tok_begin = p;
        end
      end
    endcase
  endtask

  task automatic predict_byte(logic [7:0] c, logic last);
    logic [15:0] p;
    p = text_pos;
    n_results = 0;
    if (!done) begin
      if (lex == LEX_STR) begin
        if (c == CH_QUOTE) begin
          lex = LEX_IDLE;
          feed_grammar(TOK_STR, tok_begin, span_to(p));
        end
      end else if (lex == LEX_INT) begin
        if (!is_digit(c)) begin
          lex = LEX_IDLE;
          feed_grammar(TOK_INT, tok_begin, span_to(p));
          scan_idle(c, p);
        end
      end else begin
        scan_idle(c, p);
      end
      if (last) begin
        if (lex == LEX_INT) feed_grammar(TOK_INT, tok_begin, span_to(sat_next(p)));
        else if (lex == LEX_STR) feed_grammar(TOK_BAD, '0, '0);
        feed_grammar(TOK_END, '0, '0);
      end
    end
    if (n_results > 0) byte_results[n_results - 1].last_result = 1'b1;
    for (int i = 0; i < n_results; i++) expected_q.insert(expected_q.size(), byte_results[i]);
    if (last) clear_text();
    else text_pos = sat_next(p);
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_text();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data.data_byte, in_data.last_byte);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat arrived with no result expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.result_kind, out_data.result_kind);
          check_field("key_start", want.key_start, out_data.key_start);
          check_field("key_length", want.key_length, out_data.key_length);
          check_field("value_start", want.value_start, out_data.value_start);
          check_field("value_length", want.value_length, out_data.value_length);
          check_field("value_is_integer", want.value_is_integer, out_data.value_is_integer);
          check_field("error_code", want.error_code, out_data.error_code);
          check_field("last_result", want.last_result, out_data.last_result);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fjos_pkg::*;

  localparam int RANDOM_BYTES = 1850;
  localparam int IDLE_PCT = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  int unsigned fail_count;
  int unsigned pending;

  logic [7:0]  txt[$];
  in_item_t    text_beats[$];
  int          tok_slot;
  int          bad_slot;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  flat_json_object_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fjos_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic put_byte(logic [7:0] v);
    txt.insert(txt.size(), v);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic close_text();
    in_item_t b;
    foreach (txt[i]) begin
      b.data_byte = txt[i];
      b.last_byte = (i == txt.size() - 1);
      text_beats.insert(text_beats.size(), b);
    end
    txt.delete();
  endtask

  task automatic add_gap();
    logic [7:0] b;
    int n;
    n = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      do b = 8'($urandom_range(1, 255));
      while (b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACKET || b == CH_RBRACKET ||
             b == CH_COLON || b == CH_COMMA || b == CH_QUOTE ||
             (b >= CH_ZERO && b <= CH_NINE));
      put_byte($urandom_range(1) ? 8'h20 : b);
    end
  endtask

  task automatic add_tok(tok_t want);
    tok_t t;
    logic [7:0] b;
    t = (tok_slot == bad_slot) ? tok_t'($urandom_range(TOK_LBRACE, TOK_INT)) : want;
    tok_slot++;
    add_gap();
    case (t)
      TOK_LBRACE:   put_byte(CH_LBRACE);
      TOK_RBRACE:   put_byte(CH_RBRACE);
      TOK_LBRACKET: put_byte(CH_LBRACKET);
      TOK_RBRACKET: put_byte(CH_RBRACKET);
      TOK_COLON:    put_byte(CH_COLON);
      TOK_COMMA:    put_byte(CH_COMMA);
      TOK_STR: begin
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(1, 255));
          while (b == CH_QUOTE);
          put_byte(b);
        end
        put_byte(CH_QUOTE);
      end
      TOK_INT: begin
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      default: begin
      end
    endcase
  endtask

  // Mostly well-formed objects with random content; the rest carry one wrong token,
  // are cut short, or are plain noise.
  task automatic make_text();
    int members;
    int roll;
    int cut;
    roll = $urandom_range(99);
    members = $urandom_range(1, 4);
    tok_slot = 0;
    bad_slot = (roll < 65) ? -1 : $urandom_range(0, 4 * members);
    if (roll >= 90) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(1, 255)));
    end else begin
      add_tok(TOK_LBRACE);
      for (int m = 0; m < members; m++) begin
        if (m > 0) add_tok(TOK_COMMA);
        add_tok(TOK_STR);
        add_tok(TOK_COLON);
        add_tok($urandom_range(1) ? TOK_INT : TOK_STR);
      end
      add_tok(TOK_RBRACE);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(5) == 0) begin
        cut = $urandom_range(1, txt.size());
        while (txt.size() > cut) void'(txt.pop_back());
      end
    end
    close_text();
  endtask

  initial begin : receiver
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 1500 && rx_cycle < 1800) begin
        out_stall <= 1'b1;
      end else if (rx_cycle >= 400 && rx_cycle < 900) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int base;
    int idle_pct;

    // An integer closed by the brace gives two results; the byte after is ignored.
    add_str("{\"k\":7}x");
    close_text();
    add_str("{\"a\":5");
    close_text();
    put_byte(8'h00);
    put_byte(8'h01);
    add_str("{\"\":\"");
    put_byte(8'hFF);
    add_str("\"]");
    close_text();
    add_str("{\"ab");
    close_text();
    add_str("[");
    close_text();

    base = text_beats.size();
    while (text_beats.size() < base + RANDOM_BYTES) make_text();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (text_beats[i]) begin
      idle_pct = (i >= 600 && i < 1000) ? 0 : IDLE_PCT;
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= text_beats[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fjos_pkg.sv
hw/rtl/fjos_scan.sv
hw/rtl/fjos_fifo.sv
hw/rtl/flat_json_object_scanner.sv
dv/fjos_checker.sv
dv/tb_top.sv
